// ----- rtl/core/rbb_pkg.sv -----
`default_nettype none

package rbb_pkg;

  localparam int DEFAULT_MAX_SIZE = 256;
  localparam int IMAGE_DIM_RESET  = 256;
  localparam int DIM_BITS         = 9;
  localparam int CFG_INDEX_W      = 2;
  localparam int PIXEL_BITS       = 24;
  localparam int COLSUM_W         = 10;
  localparam int SUM_W            = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [15:0] RECIP_NINE = 16'd7282;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] blue;
    logic [COLSUM_W-1:0] green;
    logic [COLSUM_W-1:0] red;
  } colsum_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sum_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SHIFT,
    OP_FINAL
  } col_op_t;

  typedef struct packed {
    logic    valid;
    logic    emit;
    logic    last;
    col_op_t op;
  } col_ctl_t;

  // sum is at most 9 * 255, so the reciprocal error never reaches one
  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+15:0] p;
    p = {16'd0, s} * {{SUM_W{1'b0}}, RECIP_NINE};
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rbb_line_store.sv -----
`default_nettype none

module rbb_line_store #(
  parameter int DEPTH = rbb_pkg::DEFAULT_MAX_SIZE
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire rbb_pkg::pixel_t          wr_top,
  input  wire rbb_pkg::pixel_t          wr_mid,
  output rbb_pkg::pixel_t               rd_top,
  output rbb_pkg::pixel_t               rd_mid
);

  import rbb_pkg::*;

  pixel_t mem_top [DEPTH];
  pixel_t mem_mid [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rd_top <= mem_top[rd_addr];
      rd_mid <= mem_mid[rd_addr];
    end
    if (wr_en) begin
      mem_top[wr_addr] <= wr_top;
      mem_mid[wr_addr] <= wr_mid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rbb_window.sv -----
`default_nettype none

module rbb_window (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire rbb_pkg::col_ctl_t ctl,
  input  wire rbb_pkg::colsum_t  col,
  output logic                   sum_valid,
  output logic                   sum_last,
  output rbb_pkg::sum_t          sum
);

  import rbb_pkg::*;

  col_ctl_t ctl_q;
  colsum_t  col_q;
  colsum_t  cs_old;
  colsum_t  cs_new;
  colsum_t  third;
  sum_t     sum_next;

  always_comb begin
    third = (ctl_q.op == OP_SHIFT) ? col_q : cs_new;
    sum_next.red   = SUM_W'(cs_old.red) + SUM_W'(cs_new.red) + SUM_W'(third.red);
    sum_next.green = SUM_W'(cs_old.green) + SUM_W'(cs_new.green) + SUM_W'(third.green);
    sum_next.blue  = SUM_W'(cs_old.blue) + SUM_W'(cs_new.blue) + SUM_W'(third.blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q.valid <= 1'b0;
      sum_valid   <= 1'b0;
    end else if (adv) begin
      ctl_q     <= ctl;
      col_q     <= col;
      sum_valid <= ctl_q.valid && ctl_q.emit;
      sum_last  <= ctl_q.last;
      sum       <= sum_next;
      if (ctl_q.valid) begin
        case (ctl_q.op)
          OP_LOAD: begin
            cs_old <= col_q;
            cs_new <= col_q;
          end
          OP_SHIFT: begin
            cs_old <= cs_new;
            cs_new <= col_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rgb_box_blur_3x3_top.sv -----
// 3x3 box blur on an RGB pixel stream.
// Input stream: one item per request; tuser[0] = 0 is an image pixel, 1 a drain tick.
// Pixels arrive in raster order; after the last pixel of a frame send width+1 drain
// ticks. Items of the wrong kind for the current position are accepted and dropped.
// Output stream: one blurred pixel per request, tlast on the last pixel of the frame.
// Each channel is the 3x3 neighbourhood sum divided by nine, truncated, with edge
// pixels replicated past all four borders.
// Throughput: one item per cycle while no result waits in the skid, set by the line
// store pair, each read at one column and written at another once per pixel. Output
// trails input by one row plus one pixel, through input, window and output registers.
// A two-entry output (register plus skid) lets input continue while one result
// waits; input tready drops only while both entries are full.
// Configuration: index 0 sets width, index 1 height, clamped to 3..MAX_SIZE; a write
// to either index restarts the frame. Write only while the stream is idle.
// Reset: synchronous; dimensions return to 256 (or MAX_SIZE if smaller), position
// counters clear, no clearing pass over the line stores is needed.
`default_nettype none

module rgb_box_blur_3x3_top #(
  parameter int MAX_SIZE = rbb_pkg::DEFAULT_MAX_SIZE
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [rbb_pkg::PIXEL_BITS-1:0]  s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic [0:0]                      s_axis_tuser,  // kind
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rbb_pkg::PIXEL_BITS-1:0]       m_axis_tdata,  // red_out, green_out, blue_out
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rbb_pkg::DIM_BITS-1:0]    cfg_data
);

  import rbb_pkg::*;

  localparam int COL_W = $clog2(MAX_SIZE);
  localparam int DIM_W = $clog2(MAX_SIZE + 1);
  localparam int ROW_W = $clog2(MAX_SIZE + 2);
  localparam int RESET_DIM = (IMAGE_DIM_RESET > MAX_SIZE) ? MAX_SIZE : IMAGE_DIM_RESET;

  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic [DIM_W-1:0] cfg_clamped;
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;

  logic adv;
  logic skid_full;
  logic pix_phase;
  logic kind_ok;
  logic take;
  logic final_item;
  logic col_last;
  logic cfg_hit;

  logic             s1_valid;
  logic             s1_final;
  logic             s1_col0;
  logic             s1_drain;
  logic             s1_row_is1;
  logic             s1_emit;
  logic [COL_W-1:0] s1_col;
  pixel_t           s1_pix;

  pixel_t   rd_top;
  pixel_t   rd_mid;
  pixel_t   top;
  pixel_t   mid;
  pixel_t   bot;
  colsum_t  col_sum;
  col_ctl_t ctl;

  logic   sum_valid;
  logic   sum_last;
  sum_t   sum;
  pixel_t result;
  logic   s3_fire;

  pixel_t out_data;
  logic   out_last;
  logic   out_valid;
  pixel_t skid_data;
  logic   skid_last;

  assign adv           = !skid_full;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;

  assign pix_phase  = in_row < ROW_W'(height_eff);
  assign final_item = in_row > ROW_W'(height_eff);
  assign kind_ok    = pix_phase ? (s_axis_tuser[0] == KIND_PIXEL)
                                : (s_axis_tuser[0] == KIND_DRAIN);
  assign take       = s_axis_tvalid && adv && kind_ok;
  assign col_last   = (DIM_W'(in_column) + DIM_W'(1)) == width_eff;
  assign cfg_hit    = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
                                    cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    if (cfg_data < DIM_BITS'(3)) begin
      cfg_clamped = DIM_W'(3);
    end else if (32'(cfg_data) > MAX_SIZE) begin
      cfg_clamped = DIM_W'(MAX_SIZE);
    end else begin
      cfg_clamped = DIM_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= DIM_W'(RESET_DIM);
      height_eff <= DIM_W'(RESET_DIM);
      in_column  <= '0;
      in_row     <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_eff  <= cfg_clamped;
        REG_IMAGE_HEIGHT: height_eff <= cfg_clamped;
        default: begin
        end
      endcase
      in_column <= '0;
      in_row    <= '0;
    end else if (take) begin
      if (final_item) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (col_last) begin
        in_column <= '0;
        in_row    <= in_row + ROW_W'(1);
      end else begin
        in_column <= in_column + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid   <= take;
      s1_final   <= final_item;
      s1_col0    <= in_column == '0;
      s1_drain   <= !pix_phase;
      s1_row_is1 <= in_row == ROW_W'(1);
      s1_emit    <= final_item || ((in_column == '0) ? (in_row >= ROW_W'(2))
                                                     : (in_row >= ROW_W'(1)));
      s1_col     <= in_column;
      s1_pix     <= pixel_t'(s_axis_tdata);
    end
  end

  rbb_line_store #(
    .DEPTH (MAX_SIZE)
  ) u_line_store (
    .clk     (clk),
    .en      (adv),
    .rd_addr (in_column),
    .wr_en   (adv && s1_valid && !s1_final),
    .wr_addr (s1_col),
    .wr_top  (mid),
    .wr_mid  (bot),
    .rd_top  (rd_top),
    .rd_mid  (rd_mid)
  );

  always_comb begin
    mid = rd_mid;
    top = s1_row_is1 ? rd_mid : rd_top;
    bot = s1_drain ? rd_mid : s1_pix;
    col_sum.red   = COLSUM_W'(top.red) + COLSUM_W'(mid.red) + COLSUM_W'(bot.red);
    col_sum.green = COLSUM_W'(top.green) + COLSUM_W'(mid.green) + COLSUM_W'(bot.green);
    col_sum.blue  = COLSUM_W'(top.blue) + COLSUM_W'(mid.blue) + COLSUM_W'(bot.blue);
    ctl.valid = s1_valid;
    ctl.emit  = s1_emit;
    ctl.last  = s1_final;
    if (s1_final) begin
      ctl.op = OP_FINAL;
    end else if (s1_col0) begin
      ctl.op = OP_LOAD;
    end else begin
      ctl.op = OP_SHIFT;
    end
  end

  rbb_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl       (ctl),
    .col       (col_sum),
    .sum_valid (sum_valid),
    .sum_last  (sum_last),
    .sum       (sum)
  );

  assign result.red   = div9(sum.red);
  assign result.green = div9(sum.green);
  assign result.blue  = div9(sum.blue);
  assign s3_fire      = adv && sum_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_full) begin
        out_data  <= skid_data;
        out_last  <= skid_last;
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else if (s3_fire) begin
        out_data  <= result;
        out_last  <= sum_last;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (s3_fire) begin
      skid_data <= result;
      skid_last <= sum_last;
      skid_full <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry held without a result on the output");

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(in_column) < width_eff)
    else $error("input column beyond the configured width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    in_row <= ROW_W'(height_eff) + ROW_W'(1))
    else $error("input row beyond the drain rows");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    take && final_item |=> in_row == '0 && in_column == '0)
    else $error("frame did not restart after its last drain request");

  a_dims_clamped: assert property (@(posedge clk) disable iff (rst)
    width_eff >= DIM_W'(3) && width_eff <= DIM_W'(MAX_SIZE) &&
    height_eff >= DIM_W'(3) && height_eff <= DIM_W'(MAX_SIZE))
    else $error("frame dimension outside its clamped range");
`endif

endmodule

`default_nettype wire
